// ----- rtl/ssfr_pkg.sv -----
package ssfr_pkg;

  localparam int unsigned ANGLE_MIN      = 40;
  localparam int unsigned ANGLE_MAX      = 150;
  localparam int unsigned TICKS_PER_STEP = 240;
  localparam int unsigned SWEEP_LIMIT    = 1023;
  localparam int unsigned PHASE_SPACING  = 60;
  localparam int unsigned PHASE_COUNT    = 9;
  localparam int unsigned ANGLE_STEP     = 2;

  localparam logic [7:0] RAMP_UP_RESET   = 8'd20;
  localparam logic [7:0] RAMP_DOWN_RESET = 8'd20;
  localparam logic [7:0] TRIP_RESET      = 8'b1000_0000;
  localparam logic [7:0] LIMIT_RESET     = 8'b0110_0100;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ZERO  = 2'd1,
    OP_CURR  = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_RAMP_UP   = 2'd0,
    CFG_RAMP_DOWN = 2'd1,
    CFG_TRIP      = 2'd2,
    CFG_LIMIT     = 2'd3
  } cfg_idx_t;

endpackage

// ----- rtl/ssfr_if.sv -----
interface ssfr_in_if;
  logic           valid;
  logic           ready;
  ssfr_pkg::op_t  op;
  logic [7:0]     current_level;

  modport source (output valid, output op, output current_level, input ready);
  modport sink (input valid, input op, input current_level, output ready);
endinterface

interface ssfr_out_if;
  logic       valid;
  logic       ready;
  logic       gate_a;
  logic       gate_b;
  logic       gate_c;
  logic       is_running;
  logic       bypass_on;
  logic       is_ramping_down;
  logic [7:0] angle_now;
  logic       limit_hold;

  modport source (
    output valid, output gate_a, output gate_b, output gate_c, output is_running,
    output bypass_on, output is_ramping_down, output angle_now, output limit_hold,
    input ready
  );
  modport sink (
    input valid, input gate_a, input gate_b, input gate_c, input is_running,
    input bypass_on, input is_ramping_down, input angle_now, input limit_hold,
    output ready
  );
endinterface

// ----- rtl/soft_starter_firing_ramp_top.sv -----
// Soft-starter firing controller for three thyristor gates.
// Items arrive on in_ch: a timer tick, a mains zero crossing, a current
// sample or a start command. Every accepted item produces exactly one result
// item on out_ch with the three gate pulses and the block status after it.
// The ramp periods and the trip and limit current levels are written through
// the cfg port; the user must write them only while the block is idle (not enforced).
// The result of each item is registered and is offered on out_ch in the cycle
// after the input item is accepted.
// One item is accepted in every cycle while out_ch is ready, set by the single output register.
// While the receiver stalls, in_ch stays ready only until the output register
// holds a result, so a pending result is never lost.
// Reset clears the output valid, stops firing, clears bypass and the hold,
// sets the firing angle to its maximum and loads the register defaults.
module soft_starter_firing_ramp_top (
  input  logic               clk,
  input  logic               rst_n,
  ssfr_in_if.sink            in_ch,
  ssfr_out_if.source         out_ch,
  input  logic               cfg_we,
  input  ssfr_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]         cfg_data
);
  import ssfr_pkg::*;

  logic [7:0] ramp_up_r, ramp_down_r, trip_r, limit_r;

  logic       running_r, running_nxt;
  logic       bypass_r, bypass_nxt;
  logic       dir_r, dir_nxt;
  logic       toggle_r, toggle_nxt;
  logic       hold_r, hold_nxt;
  logic [7:0] angle_r, angle_nxt;
  logic [9:0] sweep_r, sweep_nxt;
  logic [7:0] tdiv_r, tdiv_nxt;
  logic [7:0] steps_r, steps_nxt;

  logic       out_valid_r;
  logic       gate_a_r, gate_a_nxt;
  logic       gate_b_r, gate_b_nxt;
  logic       gate_c_r, gate_c_nxt;

  logic       in_fire;
  logic [11:0] offset;
  logic [8:0]  angle_dn, angle_up;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign angle_dn = {1'b0, angle_r} - 9'(ANGLE_STEP);
  assign angle_up = {1'b0, angle_r} + 9'(ANGLE_STEP);

  always_comb begin
    running_nxt = running_r;
    bypass_nxt  = bypass_r;
    dir_nxt     = dir_r;
    toggle_nxt  = toggle_r;
    hold_nxt    = hold_r;
    angle_nxt   = angle_r;
    sweep_nxt   = sweep_r;
    tdiv_nxt    = tdiv_r;
    steps_nxt   = steps_r;
    gate_a_nxt  = 1'b0;
    gate_b_nxt  = 1'b0;
    gate_c_nxt  = 1'b0;
    offset      = '0;
    unique case (in_ch.op)
      OP_TICK: begin
        if (running_r) begin
          if (sweep_r != 10'(SWEEP_LIMIT)) begin
            sweep_nxt = sweep_r + 10'd1;
          end
          offset = {2'b00, sweep_nxt} + 12'(2 * PHASE_SPACING) - {4'b0000, angle_r};
          for (int k = 0; k < PHASE_COUNT; k++) begin
            if (offset == 12'(k * PHASE_SPACING)) begin
              if (k % 3 == 0) gate_c_nxt = 1'b1;
              if (k % 3 == 1) gate_b_nxt = 1'b1;
              if (k % 3 == 2) gate_a_nxt = 1'b1;
            end
          end
          tdiv_nxt = tdiv_r + 8'd1;
          if (tdiv_nxt == 8'(TICKS_PER_STEP)) begin
            tdiv_nxt  = '0;
            steps_nxt = steps_r + 8'd1;
            if (!dir_r) begin
              if (steps_nxt == ramp_up_r) begin
                steps_nxt = '0;
                angle_nxt = (angle_dn < 9'(ANGLE_MIN)) ? 8'(ANGLE_MIN) : angle_dn[7:0];
              end
            end else begin
              if (steps_nxt == ramp_down_r) begin
                steps_nxt = '0;
                angle_nxt = (angle_up > 9'(ANGLE_MAX)) ? 8'(ANGLE_MAX) : angle_up[7:0];
              end
            end
          end
        end
      end
      OP_ZERO: begin
        toggle_nxt = !toggle_r;
        if (!toggle_r) begin
          sweep_nxt = '0;
        end
        if (!dir_r) begin
          if (angle_r <= 8'(ANGLE_MIN)) begin
            running_nxt = 1'b0;
            bypass_nxt  = 1'b1;
            dir_nxt     = 1'b1;
          end
        end else begin
          if (angle_r >= 8'(ANGLE_MAX)) begin
            running_nxt = 1'b0;
            dir_nxt     = 1'b0;
          end
        end
      end
      OP_CURR: begin
        if (running_r || bypass_r) begin
          priority if (in_ch.current_level > trip_r) begin
            running_nxt = 1'b0;
            bypass_nxt  = 1'b0;
            dir_nxt     = !dir_r;
          end else if (in_ch.current_level > limit_r && !hold_r) begin
            hold_nxt = 1'b1;
            dir_nxt  = !dir_r;
          end else if (hold_r && in_ch.current_level < limit_r) begin
            hold_nxt = 1'b0;
            dir_nxt  = !dir_r;
          end
        end
      end
      OP_START: begin
        if (!running_r || bypass_r) begin
          bypass_nxt  = 1'b0;
          running_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_up_r   <= RAMP_UP_RESET;
      ramp_down_r <= RAMP_DOWN_RESET;
      trip_r      <= TRIP_RESET;
      limit_r     <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAMP_UP:   ramp_up_r   <= cfg_data;
        CFG_RAMP_DOWN: ramp_down_r <= cfg_data;
        CFG_TRIP:      trip_r      <= cfg_data;
        CFG_LIMIT:     limit_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      bypass_r  <= 1'b0;
      dir_r     <= 1'b0;
      toggle_r  <= 1'b0;
      hold_r    <= 1'b0;
      angle_r   <= 8'(ANGLE_MAX);
      sweep_r   <= '0;
      tdiv_r    <= '0;
      steps_r   <= '0;
    end else if (in_fire) begin
      running_r <= running_nxt;
      bypass_r  <= bypass_nxt;
      dir_r     <= dir_nxt;
      toggle_r  <= toggle_nxt;
      hold_r    <= hold_nxt;
      angle_r   <= angle_nxt;
      sweep_r   <= sweep_nxt;
      tdiv_r    <= tdiv_nxt;
      steps_r   <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      gate_a_r <= gate_a_nxt;
      gate_b_r <= gate_b_nxt;
      gate_c_r <= gate_c_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.gate_a          = gate_a_r;
  assign out_ch.gate_b          = gate_b_r;
  assign out_ch.gate_c          = gate_c_r;
  assign out_ch.is_running      = running_r;
  assign out_ch.bypass_on       = bypass_r;
  assign out_ch.is_ramping_down = dir_r;
  assign out_ch.angle_now       = angle_r;
  assign out_ch.limit_hold      = hold_r;

endmodule

// ----- rtl/ssfr_checker.sv -----
module ssfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       gate_a,
  input logic       gate_b,
  input logic       gate_c,
  input logic       is_running,
  input logic       bypass_on,
  input logic [7:0] angle_now
);
  import ssfr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result item dropped while the receiver stalled.");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (angle_now >= 8'(ANGLE_MIN)) && (angle_now <= 8'(ANGLE_MAX)))
    else $error("Firing angle left its allowed range.");

  a_one_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({gate_a, gate_b, gate_c}))
    else $error("More than one gate fired in one item.");

  a_gate_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (gate_a || gate_b || gate_c) |-> is_running)
    else $error("A gate fired while the block was stopped.");

  a_bypass_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(is_running && bypass_on))
    else $error("Bypass is on while the ramp is running.");

endmodule

bind soft_starter_firing_ramp_top ssfr_checker u_ssfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .gate_a     (out_ch.gate_a),
  .gate_b     (out_ch.gate_b),
  .gate_c     (out_ch.gate_c),
  .is_running (out_ch.is_running),
  .bypass_on  (out_ch.bypass_on),
  .angle_now  (out_ch.angle_now)
);
